// ----- design/cbe_pkg.sv -----
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared widths, constants and the item record for the cubic Bezier easing unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cbe_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int BISECT_STEPS = 16;

    localparam int CTRL_W = 7;
    localparam int IO_W   = FRAC_BITS + 1;
    localparam int T_W    = BISECT_STEPS + 1;

    // curve evaluator widths
    localparam int P_W     = 2 * T_W;
    localparam int KW      = CTRL_W + 2;
    localparam int INNER_W = P_W + KW + 2;
    localparam int V_W     = INNER_W - BISECT_STEPS + T_W;

    // common compare scale
    localparam int SCALE_MAX = (2 * BISECT_STEPS > FRAC_BITS) ? 2 * BISECT_STEPS : FRAC_BITS;
    localparam int SH_CURVE  = SCALE_MAX - 2 * BISECT_STEPS;
    localparam int SH_TARGET = SCALE_MAX - FRAC_BITS;
    localparam int TGT_W     = IO_W + CTRL_W + SH_TARGET;
    localparam int CMP_W     = (V_W + SH_CURVE > TGT_W) ? V_W + SH_CURVE : TGT_W;

    // output rounding, divide by 127 through a reciprocal
    localparam int W_W   = IO_W + CTRL_W;
    localparam int RSH   = W_W + CTRL_W;
    localparam int REC_W = RSH - CTRL_W + 2;
    localparam logic [63:0] RECIP    = (64'd1 << RSH) / 64'd127;
    localparam logic [63:0] HALF_DIV = (64'd127 << SH_TARGET) >> 1;

    localparam logic [IO_W-1:0] ONE_Q = IO_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0]  T_ONE = T_W'(1) << BISECT_STEPS;
    localparam logic [CTRL_W-1:0] CTRL_MAX = '1;

    typedef struct packed {
        logic              valid;
        logic [CTRL_W-1:0] k1x;
        logic [CTRL_W-1:0] k1y;
        logic [CTRL_W-1:0] k2x;
        logic [CTRL_W-1:0] k2y;
        logic              diag;
        logic [IO_W-1:0]   x;
        logic [TGT_W-1:0]  target;
        logic [T_W-1:0]    lo;
        logic [T_W-1:0]    hi;
    } t_item;

endpackage

`default_nettype wire

// ----- design/cbe_if.sv -----
// ----------------------------------------------------------------------------
// cbe_in_if / cbe_out_if
// Valid/ready channels for control points with progress, and for the result.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbe_in_if
    import cbe_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CTRL_W-1:0] ctrl1_x;
    logic [CTRL_W-1:0] ctrl1_y;
    logic [CTRL_W-1:0] ctrl2_x;
    logic [CTRL_W-1:0] ctrl2_y;
    logic [IO_W-1:0]   progress;

    modport source (output valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, progress, input ready);
    modport sink   (input valid, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, progress, output ready);
endinterface

interface cbe_out_if
    import cbe_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [IO_W-1:0] eased;

    modport source (output valid, eased, input ready);
    modport sink   (input valid, eased, output ready);
endinterface

`default_nettype wire

// ----- design/cbe_curve.sv -----
// ----------------------------------------------------------------------------
// cbe_curve
// Three-stage evaluator of 127 * B(t) at scale 2^(2*BISECT_STEPS).
// ----------------------------------------------------------------------------
`default_nettype none

module cbe_curve
    import cbe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [CTRL_W-1:0] i_k1,
    input  wire logic [CTRL_W-1:0] i_k2,
    input  wire logic [T_W-1:0]    i_t,
    output logic      [V_W-1:0]    o_v
);

    logic [P_W-1:0]     r_ss2, r_st, r_tt2;
    logic [T_W-1:0]     r_t_a, r_t_b;
    logic [CTRL_W-1:0]  r_k1_a, r_k2_a;
    logic [INNER_W-1:0] r_inner;
    logic [V_W-1:0]     r_v;
    logic [T_W-1:0]     ss;
    logic [KW-1:0]      k1_3, k2_3;
    logic [INNER_W-BISECT_STEPS-1:0] inner_hi;

    assign ss       = T_ONE - i_t;
    assign k1_3     = KW'(r_k1_a) + (KW'(r_k1_a) << 1);
    assign k2_3     = KW'(r_k2_a) + (KW'(r_k2_a) << 1);
    assign inner_hi = r_inner[INNER_W-1:BISECT_STEPS];

    // stage a: products of s and t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ss2  <= P_W'(ss) * P_W'(ss);
            r_st   <= P_W'(ss) * P_W'(i_t);
            r_tt2  <= P_W'(i_t) * P_W'(i_t);
            r_t_a  <= i_t;
            r_k1_a <= i_k1;
            r_k2_a <= i_k2;
        end
    end

    // stage b: weighted inner sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inner <= INNER_W'(k1_3) * INNER_W'(r_ss2)
                     + INNER_W'(k2_3) * INNER_W'(r_st)
                     + INNER_W'(CTRL_MAX) * INNER_W'(r_tt2);
            r_t_b   <= r_t_a;
        end
    end

    // stage c: final multiply by t
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v <= V_W'(inner_hi) * V_W'(r_t_b);
        end
    end

    assign o_v = r_v;

endmodule

`default_nettype wire

// ----- design/cubic_bezier_easing_unit.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_easing_unit
// Cubic Bezier easing: bisection for t with X(t) = progress, result Y(t).
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                      | handshake
//  i_in     | in  | ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, progress | valid/ready
//  o_out    | out | eased                                        | valid/ready
//
//  one item enters per cycle while the output register is free or taken
//  each bisection step takes four stages (three for the curve evaluator,
//  one for the compare); 16 steps, then nearest-end pick, Y evaluation and
//  rounding by a reciprocal of 127
//  synchronous active-low reset clears all valid bits
//  the whole pipe advances whenever the output register is free or taken
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_easing_unit
    import cbe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cbe_in_if.sink    i_in,
    cbe_out_if.source o_out
);

    logic en;
    logic r_out_valid;
    logic [IO_W-1:0] r_out_eased;

    t_item r_s [BISECT_STEPS+1];
    t_item r_d [BISECT_STEPS][3];
    t_item r_f [3];
    t_item r_c, r_w_rec, r_q_rec;
    t_item r_g [3];
    logic [T_W-1:0] r_tsel;
    logic [W_W-1:0] r_w, r_q_w;
    logic [W_W-1:0] r_q0;

    logic [IO_W-1:0] x_sat;
    logic [V_W-1:0]  v_lo, v_hi, v_y;
    logic [CMP_W-1:0] f_xl, f_xh, f_tg, f_dl, f_dh, y_vs;
    logic [CMP_W:0]   y_sum;
    logic [W_W+REC_W-1:0] q_prod;
    logic [W_W-1:0] q_rem, q_fix;

    assign en         = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // next record after one bisection compare
    function automatic t_item step_update(t_item rec, logic [V_W-1:0] v);
        t_item          nrec;
        logic [T_W:0]   sum;
        logic [T_W-1:0] mid;
        logic [CMP_W-1:0] vs;
        nrec = rec;
        sum  = (T_W+1)'(rec.lo) + (T_W+1)'(rec.hi);
        mid  = sum[T_W:1];
        vs   = CMP_W'(v) << SH_CURVE;
        if (vs < CMP_W'(rec.target)) begin
            nrec.lo = mid;
        end else begin
            nrec.hi = mid;
        end
        return nrec;
    endfunction

    // input stage: saturate progress and form the target
    assign x_sat = (i_in.progress > ONE_Q) ? ONE_Q : i_in.progress;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s[0].valid  <= i_in.valid;
            r_s[0].k1x    <= i_in.ctrl1_x;
            r_s[0].k1y    <= i_in.ctrl1_y;
            r_s[0].k2x    <= i_in.ctrl2_x;
            r_s[0].k2y    <= i_in.ctrl2_y;
            r_s[0].diag   <= (i_in.ctrl1_x == i_in.ctrl1_y) && (i_in.ctrl2_x == i_in.ctrl2_y);
            r_s[0].x      <= x_sat;
            r_s[0].target <= (TGT_W'(x_sat) * TGT_W'(CTRL_MAX)) << SH_TARGET;
            r_s[0].lo     <= '0;
            r_s[0].hi     <= T_ONE;
        end
        if (!i_rst_n) begin
            r_s[0].valid <= 1'b0;
        end
    end

    // bisection steps
    for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_step
        logic [T_W:0]   sum;
        logic [T_W-1:0] mid;
        logic [V_W-1:0] v;

        assign sum = (T_W+1)'(r_s[i].lo) + (T_W+1)'(r_s[i].hi);
        assign mid = sum[T_W:1];

        cbe_curve u_curve (
            .i_clk (i_clk),
            .i_en  (en),
            .i_k1  (r_s[i].k1x),
            .i_k2  (r_s[i].k2x),
            .i_t   (mid),
            .o_v   (v)
        );

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[i][0] <= r_s[i];
                r_d[i][1] <= r_d[i][0];
                r_d[i][2] <= r_d[i][1];
                r_s[i+1]  <= step_update(r_d[i][2], v);
            end
            if (!i_rst_n) begin
                r_d[i][0].valid <= 1'b0;
                r_d[i][1].valid <= 1'b0;
                r_d[i][2].valid <= 1'b0;
                r_s[i+1].valid  <= 1'b0;
            end
        end
    end

    // evaluate X at both bracket ends
    cbe_curve u_curve_lo (
        .i_clk (i_clk),
        .i_en  (en),
        .i_k1  (r_s[BISECT_STEPS].k1x),
        .i_k2  (r_s[BISECT_STEPS].k2x),
        .i_t   (r_s[BISECT_STEPS].lo),
        .o_v   (v_lo)
    );

    cbe_curve u_curve_hi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_k1  (r_s[BISECT_STEPS].k1x),
        .i_k2  (r_s[BISECT_STEPS].k2x),
        .i_t   (r_s[BISECT_STEPS].hi),
        .o_v   (v_hi)
    );

    // pick the nearer bracket end
    assign f_xl = CMP_W'(v_lo) << SH_CURVE;
    assign f_xh = CMP_W'(v_hi) << SH_CURVE;
    assign f_tg = CMP_W'(r_f[2].target);
    assign f_dl = (f_tg >= f_xl) ? f_tg - f_xl : f_xl - f_tg;
    assign f_dh = (f_xh >= f_tg) ? f_xh - f_tg : f_tg - f_xh;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f[0] <= r_s[BISECT_STEPS];
            r_f[1] <= r_f[0];
            r_f[2] <= r_f[1];
            r_c    <= r_f[2];
            r_tsel <= (f_dl <= f_dh) ? r_f[2].lo : r_f[2].hi;
        end
        if (!i_rst_n) begin
            r_f[0].valid <= 1'b0;
            r_f[1].valid <= 1'b0;
            r_f[2].valid <= 1'b0;
            r_c.valid    <= 1'b0;
        end
    end

    // evaluate Y at the chosen t
    cbe_curve u_curve_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_k1  (r_c.k1y),
        .i_k2  (r_c.k2y),
        .i_t   (r_tsel),
        .o_v   (v_y)
    );

    // rounding: add half divisor, drop scale, then divide by 127
    assign y_vs   = CMP_W'(v_y) << SH_CURVE;
    assign y_sum  = (CMP_W+1)'(y_vs) + (CMP_W+1)'(HALF_DIV);
    assign q_prod = (W_W+REC_W)'(r_w) * (W_W+REC_W)'(RECIP);
    assign q_rem  = r_q_w - W_W'(r_q0 * W_W'(CTRL_MAX));
    assign q_fix  = (q_rem >= W_W'(CTRL_MAX)) ? r_q0 + W_W'(1) : r_q0;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g[0]  <= r_c;
            r_g[1]  <= r_g[0];
            r_g[2]  <= r_g[1];
            r_w_rec <= r_g[2];
            r_w     <= W_W'(y_sum >> SH_TARGET);
            r_q_rec <= r_w_rec;
            r_q_w   <= r_w;
            r_q0    <= W_W'(q_prod >> RSH);
        end
        if (!i_rst_n) begin
            r_g[0].valid  <= 1'b0;
            r_g[1].valid  <= 1'b0;
            r_g[2].valid  <= 1'b0;
            r_w_rec.valid <= 1'b0;
            r_q_rec.valid <= 1'b0;
        end
    end

    // output register with diagonal bypass and saturation
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_valid <= r_q_rec.valid;
            if (r_q_rec.diag) begin
                r_out_eased <= r_q_rec.x;
            end else if (q_fix > W_W'(ONE_Q)) begin
                r_out_eased <= ONE_Q;
            end else begin
                r_out_eased <= IO_W'(q_fix);
            end
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.eased = r_out_eased;

    // checks
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_eased <= ONE_Q))
        else $error("eased value above one");

    a_in_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s[0].valid)
        else $error("accepted item did not enter the pipe");

    a_diag_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_q_rec.valid && r_q_rec.diag) |=> (r_out_eased == $past(r_q_rec.x)))
        else $error("diagonal item not passed through");

    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s[BISECT_STEPS].valid |->
            ((r_s[BISECT_STEPS].lo <= r_s[BISECT_STEPS].hi)
             && (r_s[BISECT_STEPS].hi - r_s[BISECT_STEPS].lo <= T_W'(1))))
        else $error("bisection bracket not closed");

endmodule

`default_nettype wire
